/* rtl/dprm_pkg.sv */
`timescale 1ns / 1ps
// Shared constants for the dual pulse rate meter.
// Used by dual_pulse_rate_meter_top; depends on nothing else.
package dprm_pkg;

	// Configuration port geometry and register indexes.
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_ADDR_W-1:0] REG_TICK_MS       = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_REPORT_PERIOD = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_GAP       = 2'd2;

	// Register field widths.
	localparam int TICK_MS_W = 4;
	localparam int PERIOD_W  = 16;
	localparam int MAX_GAP_W = 13;

	// Register reset values.
	localparam logic [TICK_MS_W-1:0] TICK_MS_RST = 4'd10;
	localparam logic [PERIOD_W-1:0]  PERIOD_RST  = 16'd300;
	localparam logic [MAX_GAP_W-1:0] MAX_GAP_RST = 13'd6000;

	// Rate arithmetic: bpm = 60000 / (gap * tick_ms).
	localparam int MS_W  = MAX_GAP_W + TICK_MS_W;
	localparam int QUO_W = 16;
	localparam int DIV_CNT_W = 4;
	localparam logic [QUO_W-1:0] MS_PER_MIN = 16'd60000;

	// Stream payload widths.
	localparam int IN_DATA_W  = 8;
	localparam int BPM_W      = 8;
	localparam int OUT_DATA_W = 16;

	// Quotients above the byte range are reported as a fixed rate.
	localparam logic [QUO_W-1:0] BPM_MAX = 16'd255;
	localparam logic [BPM_W-1:0] BPM_SAT = 8'd220;

	// Channel lanes.
	localparam int NUM_CH   = 2;
	localparam int CH_WIRED = 0;
	localparam int CH_WLESS = 1;

endpackage

/* rtl/dual_pulse_rate_meter_top.sv */
`timescale 1ns / 1ps
// Two-channel pulse interval heart rate meter, top level.
// Depends on dprm_pkg for constants and register indexes.

// Every input request is one time tick carrying a wired and a wireless pulse
// flag. A tick that does not end a report period leaves the sequencer idle,
// and the next tick can be offered in the following cycle. A tick that ends
// a period with activity goes through the accept, two registered reads of each
// channel's stamp memory, a gap check, a multiply and a 16-step bit-serial
// divider per channel, then an emit state that hands the report to the output
// register once it is free. A tick ending an idle period goes straight to emit.
// The output register holds a finished report while the next tick is accepted;
// a second report waits only if the first has not yet been taken.
module dual_pulse_rate_meter_top #(
	parameter int RING_DEPTH  = 12,
	parameter int STAMP_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write port.
	input  logic                               cfg_we,
	input  logic [dprm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [dprm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	// Tick input.
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [dprm_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [0] wired_pulse, [1] wireless_pulse
	// Report output.
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [dprm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // [7:0] wired_bpm, [15:8] wireless_bpm
	output logic                               m_axis_tuser   // [0] no_activity
);
	import dprm_pkg::*;

	localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_NEW,
		ST_RD_OLD,
		ST_GAP,
		ST_MUL,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [TICK_MS_W-1:0] tick_ms_q;
	logic [PERIOD_W-1:0]  period_q;
	logic [MAX_GAP_W-1:0] max_gap_q;

	// Control state, shared and per channel.
	logic [STAMP_WIDTH-1:0] tick_q;
	logic [PTR_W-1:0]       ptr_q   [NUM_CH];
	logic [7:0]             cnt_q   [NUM_CH];
	logic [7:0]             seen_q  [NUM_CH];
	logic [RING_DEPTH-1:0]  valid_q [NUM_CH];
	logic                   timer_q;
	logic [PERIOD_W-1:0]    ttr_q;

	// Stamp memories, one per channel.
	logic [STAMP_WIDTH-1:0] ring_mem [NUM_CH][RING_DEPTH];
	logic [STAMP_WIDTH-1:0] rd_data_q [NUM_CH];
	logic                   rd_vld_q  [NUM_CH];

	// Rate computation datapath.
	logic [STAMP_WIDTH-1:0] new_stamp_q [NUM_CH];
	logic                   gap_ok_q    [NUM_CH];
	logic [MAX_GAP_W-1:0]   gap_lo_q    [NUM_CH];
	logic [MS_W-1:0]        ms_q        [NUM_CH];
	logic [MS_W-1:0]        rem_q       [NUM_CH];
	logic [QUO_W-1:0]       quo_q       [NUM_CH];
	logic [QUO_W-1:0]       dvd_q;
	logic [DIV_CNT_W-1:0]   div_cnt_q;
	logic                   idle_rpt_q;

	// Output register.
	logic                   out_vld_q;
	logic [OUT_DATA_W-1:0]  out_data_q;
	logic                   out_user_q;

	// Combinational helpers.
	logic                   acc;
	logic                   pulse    [NUM_CH];
	logic [PTR_W-1:0]       ptr_nxt  [NUM_CH];
	logic [7:0]             cnt_nxt  [NUM_CH];
	logic [PTR_W-1:0]       newest   [NUM_CH];
	logic [PTR_W-1:0]       older    [NUM_CH];
	logic [PTR_W-1:0]       rd_addr  [NUM_CH];
	logic [STAMP_WIDTH-1:0] old_stamp [NUM_CH];
	logic [STAMP_WIDTH-1:0] gap      [NUM_CH];
	logic [MS_W:0]          div_sh   [NUM_CH];
	logic [MS_W:0]          div_diff [NUM_CH];
	logic [BPM_W-1:0]       bpm      [NUM_CH];
	logic [TICK_MS_W-1:0]   tick_eff;
	logic [PERIOD_W-1:0]    period_eff;
	logic [PERIOD_W-1:0]    ttr_dec;
	logic                   any_pulse;
	logic                   expire;
	logic                   activity;
	logic                   out_free;

	assign acc           = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign tick_eff      = (tick_ms_q == '0) ? TICK_MS_W'(1) : tick_ms_q;
	assign period_eff    = (period_q == '0) ? PERIOD_W'(1) : period_q;
	assign ttr_dec       = (ttr_q != '0) ? ttr_q - PERIOD_W'(1) : ttr_q;
	assign out_free      = !out_vld_q || m_axis_tready;

	assign pulse[CH_WIRED] = s_axis_tdata[0];
	assign pulse[CH_WLESS] = s_axis_tdata[1];

	// Pointer, count and ring address arithmetic for each channel.
	always_comb begin
		for (int ln = 0; ln < NUM_CH; ln++) begin
			ptr_nxt[ln]  = ptr_q[ln];
			cnt_nxt[ln]  = cnt_q[ln];
			if (pulse[ln]) begin
				ptr_nxt[ln] = (ptr_q[ln] == PTR_LAST) ? '0 : ptr_q[ln] + PTR_W'(1);
				cnt_nxt[ln] = cnt_q[ln] + 8'd1;
			end
			newest[ln]   = (ptr_q[ln] == '0) ? PTR_LAST : ptr_q[ln] - PTR_W'(1);
			older[ln]    = (newest[ln] == '0) ? PTR_LAST : newest[ln] - PTR_W'(1);
			rd_addr[ln]  = (state_q == ST_RD_NEW) ? newest[ln] : older[ln];
			old_stamp[ln] = rd_vld_q[ln] ? rd_data_q[ln] : '0;
			gap[ln]      = new_stamp_q[ln] - old_stamp[ln];
			div_sh[ln]   = {rem_q[ln], dvd_q[QUO_W-1]};
			div_diff[ln] = div_sh[ln] - {1'b0, ms_q[ln]};
			if (idle_rpt_q || !gap_ok_q[ln])
				bpm[ln] = '0;
			else if (quo_q[ln] > BPM_MAX)
				bpm[ln] = BPM_SAT;
			else
				bpm[ln] = quo_q[ln][BPM_W-1:0];
		end
	end

	// Timer decisions for the tick being accepted.
	assign any_pulse = pulse[CH_WIRED] || pulse[CH_WLESS];
	assign expire    = timer_q && (ttr_dec == '0);
	assign activity  = (cnt_nxt[CH_WIRED] != seen_q[CH_WIRED]) ||
	                   (cnt_nxt[CH_WLESS] != seen_q[CH_WLESS]);

	// Stamp memories: a pulse writes the current tick, reads are registered.
	always_ff @(posedge clk) begin
		for (int ln = 0; ln < NUM_CH; ln++) begin
			if (acc && pulse[ln])
				ring_mem[ln][ptr_q[ln]] <= tick_q;
			rd_data_q[ln] <= ring_mem[ln][rd_addr[ln]];
		end
	end

	// Sequencer, channel state, rate datapath and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			tick_ms_q  <= TICK_MS_RST;
			period_q   <= PERIOD_RST;
			max_gap_q  <= MAX_GAP_RST;
			tick_q     <= '0;
			timer_q    <= 1'b0;
			ttr_q      <= '0;
			idle_rpt_q <= 1'b0;
			out_vld_q  <= 1'b0;
			div_cnt_q  <= '0;
			for (int ln = 0; ln < NUM_CH; ln++) begin
				ptr_q[ln]    <= '0;
				cnt_q[ln]    <= '0;
				seen_q[ln]   <= '0;
				valid_q[ln]  <= '0;
				rd_vld_q[ln] <= 1'b0;
				gap_ok_q[ln] <= 1'b0;
			end
		end else begin
			// Configuration writes; unknown indexes are ignored.
			if (cfg_we) begin
				case (cfg_addr)
					REG_TICK_MS:       tick_ms_q <= cfg_wdata[TICK_MS_W-1:0];
					REG_REPORT_PERIOD: period_q  <= cfg_wdata[PERIOD_W-1:0];
					REG_MAX_GAP:       max_gap_q <= cfg_wdata[MAX_GAP_W-1:0];
					default: ;
				endcase
			end

			// Valid bit of each entry follows the addressed read.
			for (int ln = 0; ln < NUM_CH; ln++)
				rd_vld_q[ln] <= valid_q[ln][rd_addr[ln]];

			// The output register drains when the consumer takes the report.
			if (out_vld_q && m_axis_tready)
				out_vld_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						tick_q <= tick_q + STAMP_WIDTH'(1);
						for (int ln = 0; ln < NUM_CH; ln++) begin
							ptr_q[ln] <= ptr_nxt[ln];
							cnt_q[ln] <= cnt_nxt[ln];
							if (pulse[ln])
								valid_q[ln][ptr_q[ln]] <= 1'b1;
						end
						if (!timer_q && any_pulse) begin
							timer_q <= 1'b1;
							ttr_q   <= period_eff;
						end
						if (timer_q) begin
							ttr_q <= ttr_dec;
							if (expire && !activity) begin
								// Idle period: forget all stamps and stop.
								for (int ln = 0; ln < NUM_CH; ln++)
									valid_q[ln] <= '0;
								timer_q    <= 1'b0;
								idle_rpt_q <= 1'b1;
								state_q    <= ST_EMIT;
							end else if (expire) begin
								for (int ln = 0; ln < NUM_CH; ln++)
									seen_q[ln] <= cnt_nxt[ln];
								ttr_q      <= period_eff;
								idle_rpt_q <= 1'b0;
								state_q    <= ST_RD_NEW;
							end
						end
					end
				end
				ST_RD_NEW: begin
					state_q <= ST_RD_OLD;
				end
				ST_RD_OLD: begin
					// Newest stamp arrives while the older one is addressed.
					for (int ln = 0; ln < NUM_CH; ln++)
						new_stamp_q[ln] <= rd_vld_q[ln] ? rd_data_q[ln] : '0;
					state_q <= ST_GAP;
				end
				ST_GAP: begin
					// Check the gap and drop the older stamp when the gap is valid.
					for (int ln = 0; ln < NUM_CH; ln++) begin
						gap_ok_q[ln] <= (gap[ln] != '0) &&
						                (gap[ln] <= STAMP_WIDTH'(max_gap_q));
						gap_lo_q[ln] <= gap[ln][MAX_GAP_W-1:0];
						if ((gap[ln] != '0) && (gap[ln] <= STAMP_WIDTH'(max_gap_q)))
							valid_q[ln][older[ln]] <= 1'b0;
					end
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					for (int ln = 0; ln < NUM_CH; ln++) begin
						ms_q[ln]  <= MS_W'(gap_lo_q[ln]) * MS_W'(tick_eff);
						rem_q[ln] <= '0;
						quo_q[ln] <= '0;
					end
					dvd_q     <= MS_PER_MIN;
					div_cnt_q <= DIV_CNT_W'(QUO_W - 1);
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					// One restoring division step per cycle in each lane.
					for (int ln = 0; ln < NUM_CH; ln++) begin
						if (!div_diff[ln][MS_W]) begin
							rem_q[ln] <= div_diff[ln][MS_W-1:0];
							quo_q[ln] <= {quo_q[ln][QUO_W-2:0], 1'b1};
						end else begin
							rem_q[ln] <= div_sh[ln][MS_W-1:0];
							quo_q[ln] <= {quo_q[ln][QUO_W-2:0], 1'b0};
						end
					end
					dvd_q     <= {dvd_q[QUO_W-2:0], 1'b0};
					div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
					if (div_cnt_q == '0)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_vld_q  <= 1'b1;
						out_data_q <= {bpm[CH_WLESS], bpm[CH_WIRED]};
						out_user_q <= idle_rpt_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule

/* tb/sv/dual_pulse_rate_meter_top_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for dual_pulse_rate_meter_top: random and directed ticks,
// with every expected report worked out by its own predictor. Depends on dprm_pkg.
module dual_pulse_rate_meter_top_test;
	import dprm_pkg::*;

	localparam int RING_DEPTH   = 12;
	localparam int STAMP_WIDTH  = 32;
	localparam int DRAIN_CYCLES = 32;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int EDGE_TICKS   = 130;
	localparam int PAD_W        = IN_DATA_W - 2;
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic [BPM_W-1:0] wired_bpm;
		logic [BPM_W-1:0] wireless_bpm;
		logic             no_activity;
	} rate_report_t;

	typedef enum int {
		BEAT_QUIET,
		BEAT_STEADY,
		BEAT_JITTER,
		BEAT_NOISE,
		BEAT_SPARSE
	} beat_style_t;

	// Predicts the reports of the meter and checks the ones that come out.
	class rate_report_board;
		logic [TICK_MS_W-1:0]   tick_ms;
		logic [PERIOD_W-1:0]    period;
		logic [MAX_GAP_W-1:0]   max_gap;
		logic [STAMP_WIDTH-1:0] tick_count;
		logic [STAMP_WIDTH-1:0] stamps [NUM_CH][RING_DEPTH];
		int unsigned            head [NUM_CH];
		logic [7:0]             pulses [NUM_CH];
		logic [7:0]             pulses_seen [NUM_CH];
		bit                     timer_on;
		logic [PERIOD_W-1:0]    ticks_left;
		rate_report_t           expected_reports [$];
		int unsigned            mismatches;

		function new();
			tick_ms = TICK_MS_RST;
			period = PERIOD_RST;
			max_gap = MAX_GAP_RST;
			tick_count = '0;
			timer_on = 1'b0;
			ticks_left = '0;
			mismatches = 0;
			for (int ch = 0; ch < NUM_CH; ch++) begin
				head[ch] = 0;
				pulses[ch] = '0;
				pulses_seen[ch] = '0;
				for (int slot = 0; slot < RING_DEPTH; slot++)
					stamps[ch][slot] = '0;
			end
		endfunction

		function void set_register(input logic [CFG_ADDR_W-1:0] index,
				input logic [CFG_DATA_W-1:0] value);
			case (index)
				REG_TICK_MS:       tick_ms = value[TICK_MS_W-1:0];
				REG_REPORT_PERIOD: period = value[PERIOD_W-1:0];
				REG_MAX_GAP:       max_gap = value[MAX_GAP_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [PERIOD_W-1:0] period_load();
			return (period == '0) ? 16'd1 : period;
		endfunction

		// Rate from the two newest stamps; a valid gap frees the older slot.
		function logic [BPM_W-1:0] beat_rate(input int ch);
			int newest;
			int older;
			logic [STAMP_WIDTH-1:0] gap;
			logic [31:0] span_ms;
			logic [31:0] quotient;
			newest = (head[ch] + RING_DEPTH - 1) % RING_DEPTH;
			older = (newest + RING_DEPTH - 1) % RING_DEPTH;
			gap = stamps[ch][newest] - stamps[ch][older];
			if (gap == '0 || gap > max_gap)
				return '0;
			span_ms = gap * ((tick_ms == '0) ? 32'd1 : {28'd0, tick_ms});
			quotient = {16'd0, MS_PER_MIN} / span_ms;
			stamps[ch][older] = '0;
			if (quotient > BPM_MAX)
				return BPM_SAT;
			return quotient[BPM_W-1:0];
		endfunction

		// One accepted tick request: stamp the pulses, then run the report timer.
		function void note_tick(input bit wired, input bit wireless);
			bit was_on;
			bit hit [NUM_CH];
			rate_report_t rep;
			was_on = timer_on;
			hit[CH_WIRED] = wired;
			hit[CH_WLESS] = wireless;
			for (int ch = 0; ch < NUM_CH; ch++) begin
				if (hit[ch]) begin
					stamps[ch][head[ch]] = tick_count;
					head[ch] = (head[ch] == RING_DEPTH - 1) ? 0 : head[ch] + 1;
					pulses[ch] = pulses[ch] + 8'd1;
					if (!timer_on) begin
						timer_on = 1'b1;
						ticks_left = period_load();
					end
				end
			end
			if (was_on) begin
				if (ticks_left != '0)
					ticks_left = ticks_left - 16'd1;
				if (ticks_left == '0) begin
					if (pulses[CH_WIRED] == pulses_seen[CH_WIRED] &&
							pulses[CH_WLESS] == pulses_seen[CH_WLESS]) begin
						// Quiet period: report idle, forget all stamps, stop the timer.
						rep.wired_bpm = '0;
						rep.wireless_bpm = '0;
						rep.no_activity = 1'b1;
						for (int ch = 0; ch < NUM_CH; ch++)
							for (int slot = 0; slot < RING_DEPTH; slot++)
								stamps[ch][slot] = '0;
						timer_on = 1'b0;
					end else begin
						pulses_seen[CH_WIRED] = pulses[CH_WIRED];
						pulses_seen[CH_WLESS] = pulses[CH_WLESS];
						rep.wired_bpm = beat_rate(CH_WIRED);
						rep.wireless_bpm = beat_rate(CH_WLESS);
						rep.no_activity = 1'b0;
						ticks_left = period_load();
					end
					expected_reports.push_back(rep);
				end
			end
			tick_count = tick_count + 1'b1;
		endfunction

		task report(input string what);
			mismatches++;
			$display("mismatch at %0t: %s", $time, what);
		endtask

		task check_report(input logic [OUT_DATA_W-1:0] data, input logic flag);
			rate_report_t want;
			if (expected_reports.size() == 0) begin
				report($sformatf("report %h / %b with none expected", data, flag));
				return;
			end
			want = expected_reports.pop_front();
			if (data[BPM_W-1:0] !== want.wired_bpm)
				report($sformatf("wired_bpm %0d, expected %0d",
					data[BPM_W-1:0], want.wired_bpm));
			if (data[2*BPM_W-1:BPM_W] !== want.wireless_bpm)
				report($sformatf("wireless_bpm %0d, expected %0d",
					data[2*BPM_W-1:BPM_W], want.wireless_bpm));
			if (flag !== want.no_activity)
				report($sformatf("no_activity %b, expected %b", flag, want.no_activity));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;

	rate_report_board board = new();
	int  tick_gap_pct = 0;
	int  report_stall_pct = 0;
	bit  hold_reports = 1'b0;
	int  cycles = 0;

	dual_pulse_rate_meter_top #(
		.RING_DEPTH (RING_DEPTH),
		.STAMP_WIDTH(STAMP_WIDTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("dual_pulse_rate_meter_top_test: FAIL");
			$finish;
		end
	end

	// Report side: check each taken request, then pick the next ready value.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				board.check_report(m_axis_tdata, m_axis_tuser);
			if (hold_reports)
				m_axis_tready <= 1'b0;
			else
				m_axis_tready <= ($urandom_range(99) >= report_stall_pct);
		end
	end

	// Offer one tick request, with an optional gap first, and wait until it is taken.
	task automatic send_tick(input bit wired, input bit wireless);
		logic [PAD_W-1:0] pad;
		pad = PAD_W'($urandom_range(2**PAD_W - 1));
		if (tick_gap_pct != 0 && $urandom_range(99) < tick_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {pad, wireless, wired};
		do @(posedge clk); while (!s_axis_tready);
		board.note_tick(wired, wireless);
	endtask

	// Let every expected report come out, then give the block time to go idle.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (board.expected_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_ADDR_W-1:0] index,
			input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_addr <= index;
		cfg_wdata <= value;
		@(posedge clk);
		board.set_register(index, value);
	endtask

	// Unused upper bits of the tick and maximum gap writes carry random values.
	task automatic apply_settings(input logic [TICK_MS_W-1:0] tick,
			input logic [PERIOD_W-1:0] per, input logic [MAX_GAP_W-1:0] gap);
		logic [CFG_DATA_W-1:0] noise;
		noise = CFG_DATA_W'($urandom_range(65535));
		write_register(REG_TICK_MS, {noise[CFG_DATA_W-1:TICK_MS_W], tick});
		write_register(REG_REPORT_PERIOD, per);
		noise = CFG_DATA_W'($urandom_range(65535));
		write_register(REG_MAX_GAP, {noise[CFG_DATA_W-1:MAX_GAP_W], gap});
		write_register(REG_SPARE, CFG_DATA_W'($urandom_range(65535)));
		cfg_we <= 1'b0;
	endtask

	task automatic random_settings();
		logic [MAX_GAP_W-1:0] gap;
		logic [PERIOD_W-1:0]  per;
		case ($urandom_range(9))
			0: gap = '0;
			1: gap = MAX_GAP_RST;
			2: gap = '1;
			3: gap = MAX_GAP_W'($urandom_range(2**MAX_GAP_W - 1));
			default: gap = MAX_GAP_W'($urandom_range(40, 1));
		endcase
		per = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(24, 1));
		apply_settings(TICK_MS_W'($urandom_range(15)), per, gap);
	endtask

	// Bit n of each vector is the pulse flag of tick n.
	task automatic tick_pattern(input logic [63:0] wired_bits,
			input logic [63:0] wireless_bits, input int count);
		for (int n = 0; n < count; n++)
			send_tick(wired_bits[n], wireless_bits[n]);
	endtask

	// Per channel: steady or jittered beats with random spacing, noise, sparse pulses or silence.
	task automatic run_segment(input int count);
		beat_style_t style [NUM_CH];
		int          beat [NUM_CH];
		int          offset [NUM_CH];
		bit          hit [NUM_CH];
		for (int ch = 0; ch < NUM_CH; ch++) begin
			style[ch] = beat_style_t'($urandom_range(BEAT_SPARSE));
			beat[ch] = $urandom_range(12, 1);
			offset[ch] = $urandom_range(11);
		end
		for (int n = 0; n < count; n++) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				case (style[ch])
					BEAT_QUIET:  hit[ch] = 1'b0;
					BEAT_STEADY: hit[ch] = ((n + offset[ch]) % beat[ch] == 0);
					BEAT_JITTER: hit[ch] = ((n + offset[ch]) % beat[ch] == 0) ^
						($urandom_range(99) < 15);
					BEAT_NOISE:  hit[ch] = 1'($urandom_range(1));
					default:     hit[ch] = ($urandom_range(99) < 8);
				endcase
			end
			send_tick(hit[CH_WIRED], hit[CH_WLESS]);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: 256 wired pulses wrap the 8-bit count back to its
		// last reported value, so the period ends with an idle report.
		for (int n = 0; n < 301; n++)
			send_tick(n < 256, 1'b0);
		settle();

		// Saturated rates from gaps of one and three ticks, then an idle period.
		apply_settings(4'd1, 16'd3, '1);
		tick_pattern(64'b1001, 64'b0011, 8);
		settle();
		// Zero tick length, zero period and zero maximum gap.
		apply_settings(4'd0, 16'd0, '0);
		tick_pattern(64'b0111, 64'b0101, 5);
		settle();
		// Rates at the saturation edge: 250 and 260 bpm.
		apply_settings(4'd10, 16'd25, 13'd40);
		tick_pattern(64'h0100_0001, 64'h0080_0001, 26);
		settle();

		// Longest tick, a gap equal to the maximum and one just past it:
		// one beat report, then an idle one.
		apply_settings(4'd15, 16'd64, 13'd40);
		for (int n = 0; n < EDGE_TICKS; n++)
			send_tick(n == 0 || n == 40, n == 0 || n == 41);
		settle();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tick_gap_pct = 33;
					report_stall_pct <= 83;
				end
				1: begin
					tick_gap_pct = 83;
					report_stall_pct <= 33;
				end
				default: begin
					tick_gap_pct = 0;
					report_stall_pct <= 0;
				end
			endcase
			if (phase == 2) begin
				// Reports every tick while the report side holds off.
				apply_settings(TICK_MS_W'($urandom_range(15)), 16'd1,
					MAX_GAP_W'($urandom_range(30, 1)));
				fork
					begin
						hold_reports <= 1'b1;
						repeat (300) @(posedge clk);
						hold_reports <= 1'b0;
					end
					for (int n = 0; n < 40; n++)
						send_tick(1'($urandom_range(1)), 1'b1);
				join
				settle();
			end
			for (int seg = 0; seg < 4; seg++) begin
				random_settings();
				run_segment($urandom_range(70, 30));
				settle();
			end
		end

		if (board.mismatches == 0)
			$display("dual_pulse_rate_meter_top_test: PASS");
		else
			$display("dual_pulse_rate_meter_top_test: FAIL");
		$finish;
	end

endmodule
